FILE: hdl/line_rasterizer_unit_macros.svh
// Assertion macros shared by the line rasterizer RTL.
// Included by line_rasterizer_unit.sv; no other dependencies.
`ifndef LINE_RASTERIZER_UNIT_MACROS_SVH
`define LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRAST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRAST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lrast_pkg.sv
// Shared types and constants for the line rasterizer.
// Used by the top level, front end and back end; depends on nothing.
package lrast_pkg;

  localparam int CoordBits  = 16;
  localparam int SurfBits   = 15;
  localparam int ColorBits  = 32;
  localparam int QueueDepth = 4;
  localparam int CfgIdxBits = 1;

  localparam logic [SurfBits-1:0] SurfWidthReset  = 15'd1024;
  localparam logic [SurfBits-1:0] SurfHeightReset = 15'd768;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SURFACE_WIDTH  = 1'b0,
    CFG_SURFACE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  typedef struct packed {
    logic is_start;
    logic rejected;
    logic single;
    logic step_x_neg;
    logic step_y_neg;
  } lrast_ctrl_t;

  localparam int CtrlBits = $bits(lrast_ctrl_t);

endpackage

FILE: hdl/line_rasterizer_unit.sv
// Top level of the line rasterizer: surface registers, front end, queue, back end.
// Depends on lrast_pkg, lrast_front, lrast_queue, lrast_back and the macro header.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   action, start/end x and y, color
//   out      output     out_valid_o/out_ready_i pixel x/y, color, visible, last, rejected
//   cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// Every word yields one result, held in the queue and then in the output register;
// while out_ready_i is high the back end retires one word per cycle, so a steady
// stream moves one pixel per clock. Input is taken while the four-entry queue has
// room, so out_ready_i low stalls the input only once the queue fills. Reset clears
// the queue, the walker and the output register and restores a 1024 by 768 surface.
`include "line_rasterizer_unit_macros.svh"

module line_rasterizer_unit #(
  parameter int CoordBits  = lrast_pkg::CoordBits,
  parameter int QueueDepth = lrast_pkg::QueueDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lrast_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [lrast_pkg::SurfBits-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic signed [CoordBits-1:0]          start_x_i,
  input  logic signed [CoordBits-1:0]          start_y_i,
  input  logic signed [CoordBits-1:0]          end_x_i,
  input  logic signed [CoordBits-1:0]          end_y_i,
  input  logic [lrast_pkg::ColorBits-1:0]      color_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [CoordBits-1:0]          pixel_x_o,
  output logic signed [CoordBits-1:0]          pixel_y_o,
  output logic [lrast_pkg::ColorBits-1:0]      pixel_color_o,
  output logic                                 visible_o,
  output logic                                 last_o,
  output logic                                 rejected_o
);

  localparam int SW = lrast_pkg::SurfBits;
  localparam int CB = lrast_pkg::ColorBits;
  localparam int CL = lrast_pkg::CtrlBits;
  localparam int QW = CL + 4 * CoordBits + 2 * (CoordBits + 1) + CB;

  logic [SW-1:0] surf_width_q, surf_height_q;

  lrast_pkg::lrast_ctrl_t  f_ctrl, b_ctrl;
  logic [CoordBits:0]      f_dx, f_dy, b_dx, b_dy;
  logic [CoordBits-1:0]    b_x1, b_y1, b_x2, b_y2;
  logic [CB-1:0]           b_color;
  logic [QW-1:0]           q_wdata, q_rdata;
  logic                    q_full, q_empty, push, take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_width_q  <= lrast_pkg::SurfWidthReset;
      surf_height_q <= lrast_pkg::SurfHeightReset;
    end else if (cfg_we_i) begin
      unique case (lrast_pkg::cfg_reg_e'(cfg_index_i))
        lrast_pkg::CFG_SURFACE_WIDTH:  surf_width_q  <= cfg_data_i;
        lrast_pkg::CFG_SURFACE_HEIGHT: surf_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrast_front #(
    .CoordBits(CoordBits)
  ) u_front (
    .action_i      (action_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .surf_width_i  (surf_width_q),
    .surf_height_i (surf_height_q),
    .ctrl_o        (f_ctrl),
    .delta_x_o     (f_dx),
    .delta_y_o     (f_dy)
  );

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;
  assign q_wdata    = {f_ctrl, start_x_i, start_y_i, end_x_i, end_y_i, f_dx, f_dy, color_i};

  lrast_queue #(
    .Width(QW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_wdata),
    .pop_i       (take),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  assign {b_ctrl, b_x1, b_y1, b_x2, b_y2, b_dx, b_dy, b_color} = q_rdata;
  assign take = !q_empty && (!out_valid_o || out_ready_i);

  lrast_back #(
    .CoordBits(CoordBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .ctrl_i        (b_ctrl),
    .start_x_i     ($signed(b_x1)),
    .start_y_i     ($signed(b_y1)),
    .end_x_i       ($signed(b_x2)),
    .end_y_i       ($signed(b_y2)),
    .delta_x_i     (b_dx),
    .delta_y_i     (b_dy),
    .color_i       (b_color),
    .surf_width_i  (surf_width_q),
    .surf_height_i (surf_height_q),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .visible_o     (visible_o),
    .last_o        (last_o),
    .rejected_o    (rejected_o)
  );

  `LRAST_ASSERT_IMP(a_reject_is_blank, clk_i, rst_ni, out_valid_o && rejected_o, last_o && !visible_o && (pixel_color_o == '0), "rejected result must be a blank last word")
  `LRAST_ASSERT_IMP(a_stall_has_backlog, clk_i, rst_ni, !in_ready_o, !q_empty, "input stalled while the queue is empty")
  `LRAST_ASSERT_NXT(a_take_shows_result, clk_i, rst_ni, take, out_valid_o, "a retired word did not reach the output register")

endmodule

FILE: hdl/lrast_front.sv
// Front end: classifies each incoming word, runs the off-surface reject test
// and forms the absolute deltas and step directions. Uses lrast_pkg.
module lrast_front #(
  parameter int CoordBits = lrast_pkg::CoordBits
) (
  input  logic                            action_i,
  input  logic signed [CoordBits-1:0]     start_x_i,
  input  logic signed [CoordBits-1:0]     start_y_i,
  input  logic signed [CoordBits-1:0]     end_x_i,
  input  logic signed [CoordBits-1:0]     end_y_i,
  input  logic [lrast_pkg::SurfBits-1:0]  surf_width_i,
  input  logic [lrast_pkg::SurfBits-1:0]  surf_height_i,
  output lrast_pkg::lrast_ctrl_t          ctrl_o,
  output logic [CoordBits:0]              delta_x_o,
  output logic [CoordBits:0]              delta_y_o
);

  localparam int SW   = lrast_pkg::SurfBits;
  localparam int CmpW = ((CoordBits > SW) ? CoordBits : SW) + 2;

  logic signed [CmpW-1:0] x1_e, y1_e, x2_e, y2_e, w_e, h_e;
  logic signed [CoordBits:0] x1_w, y1_w, x2_w, y2_w, dx_s, dy_s;
  logic off_side;

  assign x1_e = CmpW'(start_x_i);
  assign y1_e = CmpW'(start_y_i);
  assign x2_e = CmpW'(end_x_i);
  assign y2_e = CmpW'(end_y_i);
  assign w_e  = $signed({{(CmpW-SW){1'b0}}, surf_width_i});
  assign h_e  = $signed({{(CmpW-SW){1'b0}}, surf_height_i});

  assign off_side = (x1_e[CmpW-1] && x2_e[CmpW-1]) ||
                    ((x1_e >= w_e) && (x2_e >= w_e)) ||
                    (y1_e[CmpW-1] && y2_e[CmpW-1]) ||
                    ((y1_e >= h_e) && (y2_e >= h_e));

  assign x1_w = (CoordBits+1)'(start_x_i);
  assign y1_w = (CoordBits+1)'(start_y_i);
  assign x2_w = (CoordBits+1)'(end_x_i);
  assign y2_w = (CoordBits+1)'(end_y_i);
  assign dx_s = x2_w - x1_w;
  assign dy_s = y2_w - y1_w;

  always_comb begin
    ctrl_o.is_start   = (action_i == lrast_pkg::ACT_START);
    ctrl_o.rejected   = off_side;
    ctrl_o.single     = (start_x_i == end_x_i) && (start_y_i == end_y_i);
    ctrl_o.step_x_neg = !(start_x_i < end_x_i);
    ctrl_o.step_y_neg = !(start_y_i < end_y_i);
    delta_x_o = dx_s[CoordBits] ? $unsigned(-dx_s) : $unsigned(dx_s);
    delta_y_o = dy_s[CoordBits] ? $unsigned(-dy_s) : $unsigned(dy_s);
  end

endmodule

FILE: hdl/lrast_queue.sv
// Small first-in first-out queue between the front and back ends.
// Generic width and depth; no package dependencies.
module lrast_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/lrast_back.sv
// Back end: Bresenham walker state, error-term update and the output register.
// Takes one queued word per cycle while take_i is high; uses lrast_pkg.
module lrast_back #(
  parameter int CoordBits = lrast_pkg::CoordBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  lrast_pkg::lrast_ctrl_t              ctrl_i,
  input  logic signed [CoordBits-1:0]         start_x_i,
  input  logic signed [CoordBits-1:0]         start_y_i,
  input  logic signed [CoordBits-1:0]         end_x_i,
  input  logic signed [CoordBits-1:0]         end_y_i,
  input  logic [CoordBits:0]                  delta_x_i,
  input  logic [CoordBits:0]                  delta_y_i,
  input  logic [lrast_pkg::ColorBits-1:0]     color_i,
  input  logic [lrast_pkg::SurfBits-1:0]      surf_width_i,
  input  logic [lrast_pkg::SurfBits-1:0]      surf_height_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [CoordBits-1:0]         pixel_x_o,
  output logic signed [CoordBits-1:0]         pixel_y_o,
  output logic [lrast_pkg::ColorBits-1:0]     pixel_color_o,
  output logic                                visible_o,
  output logic                                last_o,
  output logic                                rejected_o
);

  localparam int SW   = lrast_pkg::SurfBits;
  localparam int CB   = lrast_pkg::ColorBits;
  localparam int ErrW = CoordBits + 2;
  localparam int CmpW = ((CoordBits > SW) ? CoordBits : SW) + 2;

  logic signed [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CoordBits-1:0] stop_x_q, stop_x_d, stop_y_q, stop_y_d;
  logic [CoordBits:0]          dx_q, dx_d, dy_q, dy_d;
  logic                        neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [ErrW-1:0]      err_q, err_d;
  logic [CB-1:0]               color_q, color_d;
  logic                        active_q, active_d;

  logic                        out_valid_q;
  logic signed [CoordBits-1:0] px_q, px_d, py_q, py_d;
  logic [CB-1:0]               pcol_q, pcol_d;
  logic                        vis_q, vis_d, last_q, last_d, rej_q, rej_d;

  logic signed [ErrW:0]        e2, dx_e, dy_e;
  logic signed [ErrW-1:0]      dx_r, dy_r;
  logic                        move_x, move_y;
  logic signed [CoordBits-1:0] nx, ny;
  logic signed [CoordBits-1:0] vis_x, vis_y;
  logic signed [CmpW-1:0]      vx_e, vy_e, w_e, h_e;
  logic                        in_surf;

  assign dx_r   = $signed({1'b0, dx_q});
  assign dy_r   = $signed({1'b0, dy_q});
  assign dx_e   = $signed({2'b00, dx_q});
  assign dy_e   = $signed({2'b00, dy_q});
  assign e2     = {err_q, 1'b0};
  assign move_x = (e2 > -dy_e);
  assign move_y = (e2 < dx_e);
  assign nx     = move_x ? (neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
  assign ny     = move_y ? (neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1) : cur_y_q;

  assign vis_x   = ctrl_i.is_start ? end_x_i : cur_x_q;
  assign vis_y   = ctrl_i.is_start ? end_y_i : cur_y_q;
  assign vx_e    = CmpW'(vis_x);
  assign vy_e    = CmpW'(vis_y);
  assign w_e     = $signed({{(CmpW-SW){1'b0}}, surf_width_i});
  assign h_e     = $signed({{(CmpW-SW){1'b0}}, surf_height_i});
  assign in_surf = !vx_e[CmpW-1] && (vx_e < w_e) && !vy_e[CmpW-1] && (vy_e < h_e);

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    stop_x_d = stop_x_q;
    stop_y_d = stop_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    neg_x_d  = neg_x_q;
    neg_y_d  = neg_y_q;
    err_d    = err_q;
    color_d  = color_q;
    active_d = active_q;
    px_d     = '0;
    py_d     = '0;
    pcol_d   = '0;
    vis_d    = 1'b0;
    last_d   = 1'b1;
    rej_d    = 1'b0;
    if (ctrl_i.is_start) begin
      if (ctrl_i.rejected) begin
        active_d = 1'b0;
        rej_d    = 1'b1;
      end else begin
        cur_x_d  = start_x_i;
        cur_y_d  = start_y_i;
        stop_x_d = end_x_i;
        stop_y_d = end_y_i;
        dx_d     = delta_x_i;
        dy_d     = delta_y_i;
        neg_x_d  = ctrl_i.step_x_neg;
        neg_y_d  = ctrl_i.step_y_neg;
        err_d    = $signed({1'b0, delta_x_i}) - $signed({1'b0, delta_y_i});
        color_d  = color_i;
        active_d = !ctrl_i.single;
        px_d     = end_x_i;
        py_d     = end_y_i;
        pcol_d   = color_i;
        vis_d    = in_surf;
        last_d   = ctrl_i.single;
      end
    end else if (active_q) begin
      cur_x_d  = nx;
      cur_y_d  = ny;
      err_d    = err_q - (move_x ? dy_r : '0) + (move_y ? dx_r : '0);
      last_d   = (nx == stop_x_q) && (ny == stop_y_q);
      active_d = !last_d;
      px_d     = cur_x_q;
      py_d     = cur_y_q;
      pcol_d   = color_q;
      vis_d    = in_surf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_i) begin
        active_q    <= active_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      stop_x_q <= stop_x_d;
      stop_y_q <= stop_y_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      neg_x_q  <= neg_x_d;
      neg_y_q  <= neg_y_d;
      err_q    <= err_d;
      color_q  <= color_d;
      px_q     <= px_d;
      py_q     <= py_d;
      pcol_q   <= pcol_d;
      vis_q    <= vis_d;
      last_q   <= last_d;
      rej_q    <= rej_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcol_q;
  assign visible_o     = vis_q;
  assign last_o        = last_q;
  assign rejected_o    = rej_q;

endmodule

FILE: sim/tb.sv
// Self-checking bench for line_rasterizer_unit: a directed table, then random line walks
// over several surface sizes, each output word scored against its typed table result or a Bresenham walk predictor.
// Depends on lrast_pkg and the line_rasterizer_unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrast_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int NumPhases = 8;
  localparam int WordsPerPhase = 1300 / NumPhases;
  localparam int CoordMin = -(1 << (CoordBits - 1));
  localparam int CoordMax = (1 << (CoordBits - 1)) - 1;
  localparam int PhaseCols[NumPhases] = '{32767, 1, 0, 37, 12, 32767, 200, 640};
  localparam int PhaseRows[NumPhases] = '{32767, 1, 9, 23, 0, 1, 32767, 480};

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    action_e action;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic [ColorBits-1:0] color;
  } word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic [ColorBits-1:0] color;
    logic visible;
    logic last;
    logic rejected;
  } pixel_t;

  typedef struct packed {
    word_t w;
    logic typed;
    pixel_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_index_i = CFG_SURFACE_WIDTH;
  logic [SurfBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  action_e action_i = ACT_STEP;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic [ColorBits-1:0] color_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic [ColorBits-1:0] pixel_color_o;
  logic visible_o;
  logic last_o;
  logic rejected_o;

  int surf_w = int'(SurfWidthReset);
  int surf_h = int'(SurfHeightReset);
  int walk_x = 0;
  int walk_y = 0;
  int goal_x = 0;
  int goal_y = 0;
  int span_x = 0;
  int span_y = 0;
  int err_acc = 0;
  logic x_back = 1'b0;
  logic y_back = 1'b0;
  logic walking = 1'b0;
  logic [ColorBits-1:0] walk_color = '0;

  pixel_t pixel_queue[$];
  row_t plan[$];
  int errors = 0;
  int calm = 0;
  bit quiet = 1'b0;

  line_rasterizer_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .color_i      (color_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .visible_o    (visible_o),
    .last_o       (last_o),
    .rejected_o   (rejected_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic on_surface(input int x, input int y);
    return x >= 0 && x < surf_w && y >= 0 && y < surf_h;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < CoordMin) return CoordMin;
    if (v > CoordMax) return CoordMax;
    return v;
  endfunction

  function automatic int near_edge(input int span);
    case ($urandom_range(0, 2))
      0: return clamp_coord(int'($urandom_range(0, span + 20)) - 10);
      1: return int'($urandom_range(0, 20)) - 10;
      default: return clamp_coord(span + int'($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  function automatic word_t junk_word(input action_e a);
    word_t w;
    w.action = a;
    w.start_x = CoordBits'($urandom);
    w.start_y = CoordBits'($urandom);
    w.end_x = CoordBits'($urandom);
    w.end_y = CoordBits'($urandom);
    w.color = $urandom;
    return w;
  endfunction

  function automatic row_t line_row(input action_e a, input int sx, input int sy,
                                    input int ex, input int ey,
                                    input logic [ColorBits-1:0] c, input bit typed = 1'b0,
                                    input int px = 0, input int py = 0,
                                    input logic [ColorBits-1:0] pc = '0,
                                    input bit vis = 1'b0, input bit lst = 1'b0,
                                    input bit rej = 1'b0);
    row_t r;
    r.w.action = a;
    r.w.start_x = CoordBits'(sx);
    r.w.start_y = CoordBits'(sy);
    r.w.end_x = CoordBits'(ex);
    r.w.end_y = CoordBits'(ey);
    r.w.color = c;
    r.typed = typed;
    r.res.x = CoordBits'(px);
    r.res.y = CoordBits'(py);
    r.res.color = pc;
    r.res.visible = vis;
    r.res.last = lst;
    r.res.rejected = rej;
    return r;
  endfunction

  function automatic pixel_t rasterize(input word_t w);
    pixel_t p;
    int x1, y1, x2, y2, e2;
    p = '0;
    p.last = 1'b1;
    if (w.action == ACT_START) begin
      x1 = $signed(w.start_x);
      y1 = $signed(w.start_y);
      x2 = $signed(w.end_x);
      y2 = $signed(w.end_y);
      if ((x1 < 0 && x2 < 0) || (x1 >= surf_w && x2 >= surf_w) ||
          (y1 < 0 && y2 < 0) || (y1 >= surf_h && y2 >= surf_h)) begin
        walking = 1'b0;
        p.rejected = 1'b1;
      end else begin
        walk_x = x1;
        walk_y = y1;
        goal_x = x2;
        goal_y = y2;
        span_x = (x2 >= x1) ? x2 - x1 : x1 - x2;
        span_y = (y2 >= y1) ? y2 - y1 : y1 - y2;
        x_back = !(x1 < x2);
        y_back = !(y1 < y2);
        err_acc = span_x - span_y;
        walk_color = w.color;
        p.x = w.end_x;
        p.y = w.end_y;
        p.color = w.color;
        p.visible = on_surface(x2, y2);
        p.last = (x1 == x2) && (y1 == y2);
        walking = !p.last;
      end
    end else if (walking) begin
      p.x = walk_x[CoordBits-1:0];
      p.y = walk_y[CoordBits-1:0];
      p.color = walk_color;
      p.visible = on_surface(walk_x, walk_y);
      e2 = 2 * err_acc;
      if (e2 > -span_y) begin
        err_acc -= span_y;
        walk_x += x_back ? -1 : 1;
      end
      if (e2 < span_x) begin
        err_acc += span_x;
        walk_y += y_back ? -1 : 1;
      end
      p.last = (walk_x == goal_x) && (walk_y == goal_y);
      walking = !p.last;
    end
    return p;
  endfunction

  task automatic send_word(input word_t w, input bit typed = 1'b0, input pixel_t res = '0);
    pixel_t want;
    if (calm > 0) begin
      calm--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) calm = $urandom_range(20, 60);
    end
    in_valid_i <= 1'b1;
    action_i <= w.action;
    start_x_i <= w.start_x;
    start_y_i <= w.start_y;
    end_x_i <= w.end_x;
    end_y_i <= w.end_y;
    color_i <= w.color;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = rasterize(w);
    pixel_queue.push_back(typed ? res : want);
  endtask

  task automatic set_surface(input int cols, input int rows);
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_SURFACE_WIDTH;
    cfg_data_i <= SurfBits'(cols);
    @(posedge clk_i);
    surf_w = cols;
    cfg_index_i <= CFG_SURFACE_HEIGHT;
    cfg_data_i <= SurfBits'(rows);
    @(posedge clk_i);
    surf_h = rows;
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_lines(input int budget);
    word_t w;
    int sent, steps, sx, sy, ex, ey, reach, dx, dy;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_word(junk_word(ACT_START));
          sent++;
        end
        2: begin
          send_word(junk_word(ACT_STEP));
          sent++;
        end
        default: begin
          reach = ($urandom_range(0, 7) == 0) ? 200 : 24;
          sx = near_edge(surf_w);
          sy = near_edge(surf_h);
          ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
          ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
          w = junk_word(ACT_START);
          w.start_x = CoordBits'(sx);
          w.start_y = CoordBits'(sy);
          w.end_x = CoordBits'(ex);
          w.end_y = CoordBits'(ey);
          dx = (ex >= sx) ? ex - sx : sx - ex;
          dy = (ey >= sy) ? ey - sy : sy - ey;
          steps = (dx > dy) ? dx : dy;
          case ($urandom_range(0, 5))
            0: steps = int'($urandom_range(0, steps));
            1: steps += int'($urandom_range(1, 3));
            default: ;
          endcase
          send_word(w);
          sent++;
          repeat (steps) begin
            send_word(junk_word(ACT_STEP));
            sent++;
          end
        end
      endcase
    end
  endtask

  initial begin
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(20, 80))
        @(posedge clk_i);
      if (!quiet) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {pixel_x_o, pixel_y_o, pixel_color_o, visible_o, last_o, rejected_o};
      if (pixel_queue.size() == 0) begin
        $error("unexpected output word: pixel_x %0d pixel_y %0d", got.x, got.y);
        errors++;
      end else begin
        want = pixel_queue.pop_front();
        if (got.x !== want.x) begin
          $error("pixel_x expected %0d got %0d", want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $error("pixel_y expected %0d got %0d", want.y, got.y);
          errors++;
        end
        if (got.color !== want.color) begin
          $error("pixel_color expected %h got %h", want.color, got.color);
          errors++;
        end
        if (got.visible !== want.visible) begin
          $error("visible expected %0d got %0d", want.visible, got.visible);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last expected %0d got %0d", want.last, got.last);
          errors++;
        end
        if (got.rejected !== want.rejected) begin
          $error("rejected expected %0d got %0d", want.rejected, got.rejected);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[line_rasterizer_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rows with typed results assume the 1024 by 768 surface left by reset.
    plan = {
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 0, 1, 0),
      line_row(ACT_START, 3, 4, 3, 4, 32'hFFFF_FFFF, 1, 3, 4, 32'hFFFF_FFFF, 1, 1, 0),
      line_row(ACT_STEP, -1, -1, -1, -1, 32'hFFFF_FFFF, 1, 0, 0, 32'h0, 0, 1, 0),
      line_row(ACT_START, -5, 0, -1, 10, 32'h1234_5678, 1, 0, 0, 32'h0, 0, 1, 1),
      line_row(ACT_START, 1024, 0, 2000, 5, 32'h1234_5678, 1, 0, 0, 32'h0, 0, 1, 1),
      line_row(ACT_START, 0, -1, 5, -32768, 32'h1234_5678, 1, 0, 0, 32'h0, 0, 1, 1),
      line_row(ACT_START, 0, 800, 5, 900, 32'h1234_5678, 1, 0, 0, 32'h0, 0, 1, 1),
      line_row(ACT_START, 0, 768, 10, 32767, 32'h1234_5678, 1, 0, 0, 32'h0, 0, 1, 1),
      line_row(ACT_START, -32768, -32768, 32767, 32767, 32'h0, 1,
               32767, 32767, 32'h0, 0, 0, 0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_START, 1023, 767, 1024, 768, 32'h8000_0001, 1,
               1024, 768, 32'h8000_0001, 0, 0, 0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0, 0, 1, 0),
      line_row(ACT_START, 0, 0, 5, 2, 32'hA5A5_A5A5, 1, 5, 2, 32'hA5A5_A5A5, 1, 0, 0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_START, 2, 7, 0, 0, 32'h5A5A_5A5A, 1, 0, 0, 32'h5A5A_5A5A, 1, 0, 0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0),
      line_row(ACT_START, 32767, -32768, -32768, 32767, 32'hFFFF_0000, 1,
               -32768, 32767, 32'hFFFF_0000, 0, 0, 0),
      line_row(ACT_STEP, 0, 0, 0, 0, 32'h0)
    };
    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].res);

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_surface(PhaseCols[ph], PhaseRows[ph]);
      if (ph == NumPhases - 1) quiet = 1'b1;
      random_lines(WordsPerPhase);
    end

    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[line_rasterizer_unit] OK");
    end else begin
      $display("[line_rasterizer_unit] ERROR");
    end
    $finish;
  end

endmodule
